// ===== src/seven_segment_serial_display_writer_assert.svh =====
// Assertion macros shared by the display writer RTL.
// Clock is clock, synchronous reset is reset; no other dependencies.
`ifndef SEVEN_SEGMENT_SERIAL_DISPLAY_WRITER_ASSERT_SVH
`define SEVEN_SEGMENT_SERIAL_DISPLAY_WRITER_ASSERT_SVH

// Same-cycle implication.
`define SSDW_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SSDW_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/ssdw_pkg.sv =====
// Shared types, codes and the segment table for the display writer.
// No dependencies.
package ssdw_pkg;

   localparam int DIGIT_COUNT_DEF = 6;
   localparam int DIGIT_MAX       = 6;
   localparam int REQ_DATA_W      = 40;
   localparam int RSP_DATA_W      = 8;

   localparam logic [7:0] DATA_CMD    = 8'h40;
   localparam logic [7:0] ADDR_CMD    = 8'hC0;
   localparam logic [7:0] DISP_ON_CMD = 8'h88;
   localparam logic [7:0] DISP_OFF_CMD = 8'h80;
   localparam logic [7:0] POINT_BIT   = 8'h80;

   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_ON    = 2'd2,
      KIND_OFF   = 2'd3
   } kind_type;

   typedef enum logic [15:0] {
      ST_IDLE     = 16'h0001,
      ST_START0   = 16'h0002,
      ST_START1   = 16'h0004,
      ST_START2   = 16'h0008,
      ST_BYTE     = 16'h0010,
      ST_BITDATA  = 16'h0020,
      ST_BITHIGH  = 16'h0040,
      ST_BITLOW   = 16'h0080,
      ST_ACKREL   = 16'h0100,
      ST_ACKHIGH  = 16'h0200,
      ST_ACKLOW   = 16'h0400,
      ST_ACKDRIVE = 16'h0800,
      ST_ACKZERO  = 16'h1000,
      ST_STOP0    = 16'h2000,
      ST_STOP1    = 16'h4000,
      ST_STOP2    = 16'h8000
   } step_type;

   typedef struct packed {
      logic clock_level;
      logic data_level;
      logic data_driven;
      logic busy_res;
      logic last_step;
   } pins_type;

   function automatic logic [7:0] seg_lookup(input logic [3:0] nib);
      logic [7:0] s;
      case (nib)
         4'h0: s = 8'h3F;
         4'h1: s = 8'h06;
         4'h2: s = 8'h5B;
         4'h3: s = 8'h4F;
         4'h4: s = 8'h66;
         4'h5: s = 8'h6D;
         4'h6: s = 8'h7D;
         4'h7: s = 8'h07;
         4'h8: s = 8'h7F;
         4'h9: s = 8'h6F;
         4'hA: s = 8'h77;
         4'hB: s = 8'h7C;
         4'hC: s = 8'h5F;
         4'hD: s = 8'h17;
         4'hE: s = 8'h79;
         default: s = 8'h78;
      endcase
      return s;
   endfunction

endpackage

// ===== src/ssdw_enc.sv =====
// Hex digit to segment byte encoder with decimal point merge.
// Depends on ssdw_pkg.
module ssdw_enc
   import ssdw_pkg::*;
#(
   parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
   input  logic [23:0] digit_values,
   input  logic [5:0]  point_mask,
   output logic [7:0]  seg_bytes [DIGIT_COUNT]
);

   for (genvar i = 0; i < DIGIT_COUNT; i++) begin : g_dig
      assign seg_bytes[i] = seg_lookup(digit_values[4*i +: 4])
                          | (point_mask[i] ? POINT_BIT : 8'h00);
   end

endmodule

// ===== src/ssdw_seq.sv =====
// Pin sequencer: latches commands, holds segment bytes, one pin action per tick.
// Depends on ssdw_pkg and the assertion macro header.
`include "seven_segment_serial_display_writer_assert.svh"

module ssdw_seq
   import ssdw_pkg::*;
#(
   parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step_en,
   input  logic [1:0] kind,
   input  logic [2:0] brightness,
   input  logic [7:0] seg_bytes [DIGIT_COUNT],
   output pins_type   res
);

   localparam int BPW = $clog2(DIGIT_COUNT + 2);
   localparam int IW  = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
   localparam logic [BPW-1:0] BP_LAST = BPW'(DIGIT_COUNT);
   localparam logic [BPW-1:0] BP_MAX  = BPW'(DIGIT_COUNT + 1);

   logic [7:0]     seg_ff [DIGIT_COUNT];
   step_type       step_ff, step_in;
   logic [7:0]     shift_ff, shift_in;
   logic [3:0]     bit_pos_ff, bit_pos_in;
   logic [BPW-1:0] byte_pos_ff, byte_pos_in;
   kind_type       cmd_ff, cmd_in;
   logic           clk_pin_ff, clk_pin_in;
   logic           dat_pin_ff, dat_pin_in;
   logic           drive_ff, drive_in;
   logic           busy_ff, busy_in;
   logic           seg_we;
   logic           last;
   logic [IW-1:0]  seg_idx;
   logic           more_bytes;

   // next segment byte comes from the entry after the one just sent
   assign seg_idx    = IW'(byte_pos_ff - BPW'(1));
   assign more_bytes = (cmd_ff == KIND_WRITE) && (byte_pos_ff >= BPW'(1))
                     && (byte_pos_ff <= BP_LAST);

   always_comb begin
      step_in     = step_ff;
      shift_in    = shift_ff;
      bit_pos_in  = bit_pos_ff;
      byte_pos_in = byte_pos_ff;
      cmd_in      = cmd_ff;
      clk_pin_in  = clk_pin_ff;
      dat_pin_in  = dat_pin_ff;
      drive_in    = drive_ff;
      busy_in     = busy_ff;
      seg_we      = 1'b0;
      last        = 1'b0;
      if (step_en) begin
         if (kind_type'(kind) != KIND_TICK) begin
            if (!busy_ff) begin
               cmd_in      = kind_type'(kind);
               busy_in     = 1'b1;
               step_in     = ST_START0;
               byte_pos_in = '0;
               bit_pos_in  = '0;
               case (kind_type'(kind))
                  KIND_WRITE: begin
                     seg_we   = 1'b1;
                     shift_in = DATA_CMD;
                  end
                  KIND_ON:  shift_in = DISP_ON_CMD | {5'b0, brightness};
                  default:  shift_in = DISP_OFF_CMD;
               endcase
            end
         end else if (busy_ff) begin
            case (step_ff)
               ST_START0: begin drive_in = 1'b1; step_in = ST_START1; end
               ST_START1: begin dat_pin_in = 1'b0; step_in = ST_START2; end
               ST_START2: begin clk_pin_in = 1'b0; step_in = ST_BYTE; end
               ST_BYTE: begin
                  drive_in   = 1'b1;
                  bit_pos_in = '0;
                  step_in    = ST_BITDATA;
               end
               ST_BITDATA: begin
                  dat_pin_in = shift_ff[bit_pos_ff[2:0]];
                  step_in    = ST_BITHIGH;
               end
               ST_BITHIGH: begin clk_pin_in = 1'b1; step_in = ST_BITLOW; end
               ST_BITLOW: begin
                  clk_pin_in = 1'b0;
                  bit_pos_in = bit_pos_ff + 4'd1;
                  step_in    = (bit_pos_in >= 4'd8) ? ST_ACKREL : ST_BITDATA;
               end
               ST_ACKREL:   begin drive_in = 1'b0; step_in = ST_ACKHIGH; end
               ST_ACKHIGH:  begin clk_pin_in = 1'b1; step_in = ST_ACKLOW; end
               ST_ACKLOW:   begin clk_pin_in = 1'b0; step_in = ST_ACKDRIVE; end
               ST_ACKDRIVE: begin drive_in = 1'b1; step_in = ST_ACKZERO; end
               ST_ACKZERO: begin
                  dat_pin_in = 1'b0;
                  if (more_bytes) begin
                     byte_pos_in = byte_pos_ff + BPW'(1);
                     shift_in    = seg_ff[seg_idx];
                     step_in     = ST_BYTE;
                  end else begin
                     step_in = ST_STOP0;
                  end
               end
               ST_STOP0: begin clk_pin_in = 1'b1; step_in = ST_STOP1; end
               ST_STOP1: begin dat_pin_in = 1'b1; step_in = ST_STOP2; end
               ST_STOP2: begin
                  drive_in = 1'b0;
                  if (cmd_ff == KIND_WRITE && byte_pos_ff == '0) begin
                     // second frame: address command then the digits
                     byte_pos_in = BPW'(1);
                     shift_in    = ADDR_CMD;
                     step_in     = ST_START0;
                  end else begin
                     step_in = ST_IDLE;
                     busy_in = 1'b0;
                     last    = 1'b1;
                  end
               end
               default: begin
                  step_in = ST_IDLE;
                  busy_in = 1'b0;
               end
            endcase
         end
      end
      res.clock_level = clk_pin_in;
      res.data_level  = drive_in & dat_pin_in;
      res.data_driven = drive_in;
      res.busy_res    = busy_in;
      res.last_step   = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff     <= ST_IDLE;
         shift_ff    <= '0;
         bit_pos_ff  <= '0;
         byte_pos_ff <= '0;
         cmd_ff      <= KIND_TICK;
         clk_pin_ff  <= 1'b1;
         dat_pin_ff  <= 1'b1;
         drive_ff    <= 1'b0;
         busy_ff     <= 1'b0;
      end else begin
         step_ff     <= step_in;
         shift_ff    <= shift_in;
         bit_pos_ff  <= bit_pos_in;
         byte_pos_ff <= byte_pos_in;
         cmd_ff      <= cmd_in;
         clk_pin_ff  <= clk_pin_in;
         dat_pin_ff  <= dat_pin_in;
         drive_ff    <= drive_in;
         busy_ff     <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (seg_we) begin
         seg_ff <= seg_bytes;
      end
   end

   `SSDW_ASSERT_NOW(a_busy_not_idle, busy_ff, step_ff != ST_IDLE, "busy while idle step")
   `SSDW_ASSERT_NOW(a_idle_not_busy, !busy_ff, step_ff == ST_IDLE, "idle flag in active step")
   `SSDW_ASSERT_NOW(a_byte_pos, 1'b1, byte_pos_ff <= BP_MAX, "byte position out of range")
   `SSDW_ASSERT_NOW(a_bit_pos, 1'b1, bit_pos_ff <= 4'd8, "bit position out of range")
   `SSDW_ASSERT_NEXT(a_last_ends, step_en && res.last_step, !busy_ff, "busy after final step")

endmodule

// ===== src/seven_segment_serial_display_writer.sv =====
// Top level of the two-wire seven-segment display writer.
// Depends on ssdw_pkg, ssdw_enc and ssdw_seq.
//
// Takes one transaction per clock on req_ while rsp_ is not stalled and returns
// exactly one on rsp_ for each, after an input register and a result register;
// the input register can still take a new transaction while a result waits
// in the result register. req_tuser selects the kind: tick,
// write digits, display on or display off. A command is latched only when the
// writer is idle and ignored otherwise. Every tick then performs one pin action,
// so the serial bit rate is set by how often ticks arrive. A display on/off
// sequence takes 36 ticks; a digit write takes 72 + 30 * DIGIT_COUNT ticks
// (252 for six digits). Each result reports the clock pin, the data pin (0 when
// released), whether data is driven and whether a sequence is in progress;
// rsp_tlast marks the tick doing the final pin action. The acknowledge slot
// releases the data line but is not sampled.
module seven_segment_serial_display_writer
   import ssdw_pkg::*;
#(
   parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [23:0] digit_values, [29:24] point_mask, [32:30] brightness, [39:33] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] kind
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] clock_level, [1] data_level, [2] data_driven, [3] busy_res, [7:4] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   // input register
   logic        s1_valid_ff;
   logic [1:0]  s1_kind_ff;
   logic [23:0] s1_digits_ff;
   logic [5:0]  s1_points_ff;
   logic [2:0]  s1_bright_ff;

   // result register
   logic        rsp_valid_ff;
   pins_type    rsp_pins_ff;

   logic        s1_fire;
   logic        req_fire;
   logic [7:0]  seg_bytes [DIGIT_COUNT];
   pins_type    step_res;

   // stage 1 moves on when the result register is empty or being drained
   assign s1_fire    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_fire;
   assign req_fire   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_kind_ff   <= req_tuser;
         s1_digits_ff <= req_tdata[23:0];
         s1_points_ff <= req_tdata[29:24];
         s1_bright_ff <= req_tdata[32:30];
      end
   end

   ssdw_enc #(
      .DIGIT_COUNT (DIGIT_COUNT)
   ) u_enc (
      .digit_values (s1_digits_ff),
      .point_mask   (s1_points_ff),
      .seg_bytes    (seg_bytes)
   );

   ssdw_seq #(
      .DIGIT_COUNT (DIGIT_COUNT)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .step_en    (s1_fire),
      .kind       (s1_kind_ff),
      .brightness (s1_bright_ff),
      .seg_bytes  (seg_bytes),
      .res        (step_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_tready) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_pins_ff <= step_res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_pins_ff.busy_res, rsp_pins_ff.data_driven,
                        rsp_pins_ff.data_level, rsp_pins_ff.clock_level};
   assign rsp_tlast  = rsp_pins_ff.last_step;

endmodule
